/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the generator.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, aborted while reset is high.
`define MTG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs across reset.
`define MTG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mtg_pkg.sv */
// Shared constants, types and word functions of the MT19937 generator.
// No dependencies.
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = $clog2(STATE_WORDS);

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;

  // Codes of the action field
  typedef enum logic {
    ACT_SEED = 1'b0,
    ACT_DRAW = 1'b1
  } action_t;

  // Seeder to chain: word to shift in and whether the seeder owns the chain
  typedef struct packed {
    logic        busy;
    logic        shift;
    logic [31:0] word;
  } seed_ctl_t;

  // One step of the twist recurrence
  function automatic logic [31:0] twist(input logic [31:0] cur, input logic [31:0] nxt,
                                        input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] v;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  // Output tempering
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* rtl/mtg_cell.sv */
// One state word of the generator's shift chain.
// Depends on nothing; instantiated once per state word by the top level.
module mtg_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] din,
  output logic [31:0] dout
);

  logic [31:0] word;

  // Take the neighbour's word whenever the chain advances
  always_ff @(posedge clk) begin
    if (en) begin
      word <= din;
    end
  end

  assign dout = word;

endmodule

/* rtl/mtg_seeder.sv */
// Seed sequencer: runs the 1812433253 recurrence, each word through a multiply and an add state.
// Depends on mtg_pkg.
module mtg_seeder (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        seed,
  output mtg_pkg::seed_ctl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_ADD
  } state_t;

  state_t                   state;
  logic [31:0]              prev;
  logic [31:0]              prod;
  logic [mtg_pkg::IDX_W-1:0] idx;
  logic [31:0]              mixed;
  logic [31:0]              word_next;

  assign mixed     = prev ^ (prev >> 30);
  assign word_next = prod + {{(32 - mtg_pkg::IDX_W){1'b0}}, idx};

  // Sequencer; after reset it loads the default seed by itself
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      prev  <= mtg_pkg::DEFAULT_SEED;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            prev  <= seed;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          idx   <= mtg_pkg::IDX_W'(1);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= mtg_pkg::SEED_MULT * mixed;
          state <= S_ADD;
        end
        S_ADD: begin
          prev <= word_next;
          if (idx == mtg_pkg::IDX_W'(mtg_pkg::STATE_WORDS - 1)) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + mtg_pkg::IDX_W'(1);
            state <= S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Word offered to the tail of the chain
  always_comb begin
    ctl.busy  = (state != S_IDLE);
    ctl.shift = (state == S_LOAD) || (state == S_ADD);
    ctl.word  = (state == S_LOAD) ? prev : word_next;
  end

endmodule

/* rtl/mersenne_twister_generator_core.sv */
// MT19937 generator core. The 624-word state sits in a chain of word cells; each draw
// twists the two words at the head of the chain and the one at offset 397, shifts the new
// word in at the tail and returns it tempered, so draws run at one word per cycle whenever
// the output side takes them and no seed pass runs. A seed word occupies the block: the
// first state word enters from the load state and each further one passes through the
// multiply and add states, with in_stall high. After reset the block runs the same pass
// with seed 5489, in_stall high, so a draw before any seed sees the default state.
// Depends on mtg_pkg, mtg_cell and mtg_seeder.
module mersenne_twister_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] random_word
);

  mtg_pkg::seed_ctl_t seed_ctl;
  logic [31:0]        chain [mtg_pkg::STATE_WORDS];
  logic               in_take;
  logic               seed_go;
  logic               draw;
  logic               shift;
  logic [31:0]        tail;
  logic [31:0]        twisted;

  // Input handshake
  assign in_stall = seed_ctl.busy || (out_valid && out_stall);
  assign in_take  = in_valid && !in_stall;
  assign seed_go  = in_take && (action == mtg_pkg::ACT_SEED);
  assign draw     = in_take && (action == mtg_pkg::ACT_DRAW);

  mtg_seeder u_seeder (
    .clk   (clk),
    .rst   (rst),
    .start (seed_go),
    .seed  (seed_value),
    .ctl   (seed_ctl)
  );

  // Next state word from the head of the chain
  assign twisted = mtg_pkg::twist(chain[0], chain[1], chain[mtg_pkg::TWIST_OFFSET]);
  assign shift   = seed_ctl.shift || draw;
  assign tail    = seed_ctl.busy ? seed_ctl.word : twisted;

  // Chain of state words, head at index 0
  for (genvar gi = 0; gi < mtg_pkg::STATE_WORDS; gi++) begin : g_cell
    if (gi == mtg_pkg::STATE_WORDS - 1) begin : g_tail
      mtg_cell u_cell (.clk(clk), .en(shift), .din(tail), .dout(chain[gi]));
    end else begin : g_body
      mtg_cell u_cell (.clk(clk), .en(shift), .din(chain[gi + 1]), .dout(chain[gi]));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (draw) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      random_word <= mtg_pkg::temper(twisted);
    end
  end

endmodule

/* rtl/mtg_checker.sv */
// Port-level checks on the generator core, bound to the top level.
// Depends on assert_macros.svh and mtg_pkg.
`include "assert_macros.svh"

module mtg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] random_word
);

  logic seed_take;
  logic draw_take;

  assign seed_take = in_valid && !in_stall && (action == mtg_pkg::ACT_SEED);
  assign draw_take = in_valid && !in_stall && (action == mtg_pkg::ACT_DRAW);

  // Held output word must not move
  `MTG_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(random_word), "output word changed while stalled")

  // A draw gives a word in the next cycle
  `MTG_ASSERT(a_draw_word, clk, rst, draw_take |=> out_valid, "draw gave no output word")

  // A seed blocks the input while the state is loaded
  `MTG_ASSERT(a_seed_busy, clk, rst, seed_take |=> in_stall, "input not stalled during seeding")

  // Start-up seeding pass follows reset
  `MTG_ASSERT_ALWAYS(a_reset_busy, clk, rst |=> in_stall && !out_valid, "no start-up pass after reset")

endmodule

bind mersenne_twister_generator_core mtg_checker u_mtg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .action      (action),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .random_word (random_word)
);

/* bench/testbench.sv */
// Self-checking bench for mersenne_twister_generator_core: seeds and draws against an
// in-bench MT19937 state copy, with random idling on both handshakes.
// Depends on mtg_pkg and the generator RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    mtg_pkg::action_t act;
    logic [31:0]      seed;
  } gen_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = mtg_pkg::ACT_SEED;
  logic [31:0] seed_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] random_word;

  mersenne_twister_generator_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .seed_value  (seed_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word)
  );

  // Bench copy of the generator state
  logic [31:0] mt_words [0:mtg_pkg::STATE_WORDS-1];
  int          mt_pos = mtg_pkg::STATE_WORDS;
  bit          mt_seeded = 1'b0;

  gen_item_t   pending[$];
  logic [31:0] expected_words[$];
  gen_item_t   cur;
  int          fail_count = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          idle_pct = 15;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Last part of the run goes without idling
  function automatic bit quiet();
    return (pending.size() < 150);
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic mt_load(input logic [31:0] s);
    mt_words[0] = s;
    for (int i = 1; i < mtg_pkg::STATE_WORDS; i++) begin
      mt_words[i] = mtg_pkg::SEED_MULT * (mt_words[i-1] ^ (mt_words[i-1] >> 30)) + 32'(i);
    end
    mt_pos    = mtg_pkg::STATE_WORDS;
    mt_seeded = 1'b1;
  endtask

  // In-place twist of the whole state, in index order
  task automatic mt_regenerate();
    logic [31:0] y;
    logic [31:0] v;
    for (int k = 0; k < mtg_pkg::STATE_WORDS; k++) begin
      y = (mt_words[k] & 32'h8000_0000) |
          (mt_words[(k + 1) % mtg_pkg::STATE_WORDS] & 32'h7fff_ffff);
      v = mt_words[(k + mtg_pkg::TWIST_OFFSET) % mtg_pkg::STATE_WORDS] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ mtg_pkg::TWIST_MATRIX;
      end
      mt_words[k] = v;
    end
    mt_pos = 0;
  endtask

  function automatic logic [31:0] tempered(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & 32'h9d2c_5680);
    t = t ^ ((t << 15) & 32'hefc6_0000);
    t = t ^ (t >> 18);
    return t;
  endfunction

  // Advance the state by one accepted word and queue any output it gives
  task automatic mt_apply(input gen_item_t it);
    if (it.act == mtg_pkg::ACT_SEED) begin
      mt_load(it.seed);
    end else begin
      if (!mt_seeded) begin
        mt_load(mtg_pkg::DEFAULT_SEED);
      end
      if (mt_pos >= mtg_pkg::STATE_WORDS) begin
        mt_regenerate();
      end
      expected_words = {expected_words, tempered(mt_words[mt_pos])};
      mt_pos++;
    end
  endtask

  task automatic add_item(input mtg_pkg::action_t a, input logic [31:0] s);
    gen_item_t it;
    it.act  = a;
    it.seed = s;
    pending = {pending, it};
  endtask

  task automatic add_draws(input int n);
    for (int i = 0; i < n; i++) begin
      add_item(mtg_pkg::ACT_DRAW, $urandom());
    end
  endtask

  // Driver: hold a stalled word, otherwise idle in bursts or send the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        mt_apply(cur);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          if (!quiet() && $urandom_range(0, 99) < idle_pct) begin
            gap_left = $urandom_range(0, 5);
            in_valid <= 1'b0;
          end else begin
            cur = pending.pop_front();
            action     <= cur.act;
            seed_value <= cur.seed;
            in_valid   <= 1'b1;
            // change idling density now and then, including stretches with none
            if ($urandom_range(0, 63) == 0) begin
              case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 35;
              endcase
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet() && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: each accepted word against the oldest prediction
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word %08h", random_word));
      end else begin
        want = expected_words.pop_front();
        if (random_word !== want) begin
          report($sformatf("random_word %08h, want %08h", random_word, want));
        end
      end
    end
  end

  initial begin
    int total;
    int run;
    logic [31:0] s;

    // Directed: draws before any seed, extreme seeds, reseed with no draw
    add_draws(3);
    add_item(mtg_pkg::ACT_SEED, 32'h0000_0000);
    add_item(mtg_pkg::ACT_DRAW, 32'hffff_ffff);
    add_item(mtg_pkg::ACT_DRAW, 32'h0000_0000);
    add_item(mtg_pkg::ACT_SEED, 32'hffff_ffff);
    add_item(mtg_pkg::ACT_DRAW, 32'h0000_0000);
    add_item(mtg_pkg::ACT_SEED, mtg_pkg::DEFAULT_SEED);
    add_item(mtg_pkg::ACT_DRAW, 32'hffff_ffff);
    add_item(mtg_pkg::ACT_SEED, 32'h8000_0000);
    add_draws(1);
    add_item(mtg_pkg::ACT_SEED, 32'h7fff_ffff);
    add_draws(1);
    add_item(mtg_pkg::ACT_SEED, 32'h1234_5678);
    add_item(mtg_pkg::ACT_SEED, 32'h0000_0001);
    add_draws(2);
    add_item(mtg_pkg::ACT_SEED, 32'h5555_5555);
    add_item(mtg_pkg::ACT_SEED, 32'haaaa_aaaa);
    add_draws(1);

    // Random: mostly a seed, then a run of draws, some long enough to twist a second time
    total = pending.size();
    while (total < 1950) begin
      case ($urandom_range(0, 3))
        1: s = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
        2: s = 32'd1 << $urandom_range(0, 31);
        default: s = $urandom();
      endcase
      if ($urandom_range(0, 7) != 0) begin
        add_item(mtg_pkg::ACT_SEED, s);
        total++;
      end
      case ($urandom_range(0, 9))
        0: run = 0;
        1, 2: run = $urandom_range(625, 1300);
        default: run = $urandom_range(1, 40);
      endcase
      // keep the item count near its target
      if (run > 1950 - total) begin
        run = 1950 - total;
      end
      add_draws(run);
      total += run;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    // a trailing seed keeps the block busy for its reload pass
    repeat (1400) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS mersenne_twister_generator_core");
    end else begin
      $display("FAIL mersenne_twister_generator_core");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL mersenne_twister_generator_core");
    $finish;
  end

endmodule
